/* hdl/laft_pkg.sv */
// shared types, register indexes and helpers for the led address frame transmitter
`default_nettype none

package laft_pkg;

   localparam int FRAME_BYTES    = 4;
   localparam int BYTE_IDX_WIDTH = $clog2(FRAME_BYTES);
   localparam int CSR_IDX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH = 16;
   localparam int TICK_WIDTH     = 16;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BIT_TICKS    = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BREAK_TICKS  = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MARK_TICKS   = 2'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_COMMAND_BYTE = 2'd3;

   localparam logic [7:0]  BIT_TICKS_RESET    = 8'd4;
   localparam logic [15:0] BREAK_TICKS_RESET  = 16'd10000;
   localparam logic [7:0]  MARK_TICKS_RESET   = 8'd12;
   localparam logic [7:0]  COMMAND_BYTE_RESET = 8'hD2;

   localparam logic ACTION_TICK  = 1'b0;
   localparam logic ACTION_START = 1'b1;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_BREAK = 3'd1,
      PH_MARK  = 3'd2,
      PH_START = 3'd3,
      PH_DATA  = 3'd4,
      PH_STOP  = 3'd5
   } phase_type;

   typedef struct packed {
      logic       action;
      logic [9:0] address;
   } req_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
      logic frame_done;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  bit_ticks;
      logic [15:0] break_ticks;
      logic [7:0]  mark_ticks;
      logic [7:0]  command_byte;
   } cfg_type;

   function automatic logic [7:0] rev8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[7-i] = v[i];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* hdl/laft_sequencer.sv */
// frame sequencer: pattern bytes, phase timing and line level for each transfer
`default_nettype none

module laft_sequencer (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire laft_pkg::req_type item,
   input  wire laft_pkg::cfg_type cfg,
   output laft_pkg::rsp_type     result
);
   import laft_pkg::*;

   phase_type                 phase_ff, phase_in;
   logic [TICK_WIDTH-1:0]     tick_count_ff, tick_count_in;
   logic [3:0]                bit_index_ff, bit_index_in;
   logic [BYTE_IDX_WIDTH-1:0] byte_index_ff, byte_index_in;
   logic                      line_ff, line_in;
   logic [7:0]                pattern_ff [FRAME_BYTES];
   logic [7:0]                pattern_in [FRAME_BYTES];
   logic                      done;

   logic                      start_go;
   logic                      tick_go;
   logic [TICK_WIDTH-1:0]     tick_inc;
   logic [TICK_WIDTH-1:0]     phase_len;
   logic                      period_end;
   logic [3:0]                bit_next;
   logic                      last_byte;
   logic [11:0]               channel;
   logic [3:0]                channel_hi;
   logic [7:0]                hi_byte;

   assign start_go  = (item.action == ACTION_START) && (phase_ff == PH_IDLE);
   assign tick_go   = (item.action == ACTION_TICK) && (phase_ff != PH_IDLE);
   assign tick_inc  = tick_count_ff + 1'b1;
   assign bit_next  = bit_index_ff + 1'b1;
   assign last_byte = (byte_index_ff == BYTE_IDX_WIDTH'(FRAME_BYTES - 1));

   // channel = address * 3 + 1, high part scaled by 15 below 240
   assign channel    = ({2'b00, item.address} << 1) + {2'b00, item.address} + 12'd1;
   assign channel_hi = channel[11:8];
   assign hi_byte    = 8'd240 - (({4'b0000, channel_hi} << 4) - {4'b0000, channel_hi});

   always_comb begin
      unique case (phase_ff)
         PH_BREAK: phase_len = cfg.break_ticks;
         PH_MARK:  phase_len = {8'd0, cfg.mark_ticks};
         PH_STOP:  phase_len = {7'd0, cfg.bit_ticks, 1'b0};
         default:  phase_len = {8'd0, cfg.bit_ticks};
      endcase
   end

   // a zero length ends on the first tick since the count is already one
   assign period_end = (tick_inc >= phase_len);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (start_go) begin
         phase_in = PH_BREAK;
      end else if (tick_go && period_end) begin
         unique case (phase_ff)
            PH_BREAK: phase_in = PH_MARK;
            PH_MARK:  phase_in = PH_START;
            PH_START: phase_in = PH_DATA;
            PH_DATA:  phase_in = bit_next[3] ? PH_STOP : PH_DATA;
            PH_STOP:  phase_in = last_byte ? PH_IDLE : PH_START;
            default:  phase_in = PH_IDLE;
         endcase
      end
   end

   // counters, pattern and line level
   always_comb begin
      tick_count_in = tick_count_ff;
      bit_index_in  = bit_index_ff;
      byte_index_in = byte_index_ff;
      line_in       = line_ff;
      done          = 1'b0;
      for (int i = 0; i < FRAME_BYTES; i++) begin
         pattern_in[i] = pattern_ff[i];
      end
      if (start_go) begin
         pattern_in[0] = 8'h00;
         pattern_in[1] = rev8(channel[7:0]);
         pattern_in[2] = rev8(hi_byte);
         pattern_in[3] = rev8(cfg.command_byte);
         tick_count_in = '0;
         bit_index_in  = '0;
         byte_index_in = '0;
         line_in       = 1'b0;
      end else if (tick_go) begin
         tick_count_in = tick_inc;
         if (period_end) begin
            tick_count_in = '0;
            unique case (phase_ff)
               PH_BREAK: line_in = 1'b1;
               PH_MARK:  line_in = 1'b0;
               PH_START: begin
                  bit_index_in = '0;
                  line_in      = pattern_ff[byte_index_ff][0];
               end
               PH_DATA: begin
                  bit_index_in = bit_next;
                  line_in      = bit_next[3] ? 1'b1 : pattern_ff[byte_index_ff][bit_next[2:0]];
               end
               PH_STOP: begin
                  bit_index_in = '0;
                  if (last_byte) begin
                     byte_index_in = '0;
                     line_in       = 1'b1;
                     done          = 1'b1;
                  end else begin
                     byte_index_in = byte_index_ff + 1'b1;
                     line_in       = 1'b0;
                  end
               end
               default: line_in = 1'b1;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         tick_count_ff <= '0;
         bit_index_ff  <= '0;
         byte_index_ff <= '0;
         line_ff       <= 1'b1;
      end else if (step) begin
         phase_ff      <= phase_in;
         tick_count_ff <= tick_count_in;
         bit_index_ff  <= bit_index_in;
         byte_index_ff <= byte_index_in;
         line_ff       <= line_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         for (int i = 0; i < FRAME_BYTES; i++) begin
            pattern_ff[i] <= pattern_in[i];
         end
      end
   end

   assign result.line_level = line_in;
   assign result.busy_res   = (phase_in != PH_IDLE);
   assign result.frame_done = done;

endmodule

`default_nettype wire

/* hdl/led_address_frame_transmitter_core.sv */
// top level of the led address frame transmitter: config registers and result buffer
`default_nettype none

// Each transfer is either one time tick or a start request with an LED address;
// every transfer returns one result with the line level, busy and frame done.
// One transfer is taken every clock while req_stall is low: the sequencer state
// updates in the same cycle and its result lands in a two-entry output buffer,
// so the result is registered before it shows on rsp_. req_stall rises only when
// both buffer entries hold results the consumer has not taken. Configuration writes
// are applied at once and take effect on the next transfer; a start latches
// command_byte into the frame pattern.
module led_address_frame_transmitter_core (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire laft_pkg::req_type                     req_data,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output laft_pkg::rsp_type                          rsp_data,
   input  wire logic                                  csr_write,
   input  wire logic [laft_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  wire logic [laft_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import laft_pkg::*;

   cfg_type cfg_ff;
   rsp_type result;
   logic    accept;

   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_ticks    <= BIT_TICKS_RESET;
         cfg_ff.break_ticks  <= BREAK_TICKS_RESET;
         cfg_ff.mark_ticks   <= MARK_TICKS_RESET;
         cfg_ff.command_byte <= COMMAND_BYTE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_BIT_TICKS:    cfg_ff.bit_ticks    <= csr_wdata[7:0];
            CSR_BREAK_TICKS:  cfg_ff.break_ticks  <= csr_wdata;
            CSR_MARK_TICKS:   cfg_ff.mark_ticks   <= csr_wdata[7:0];
            CSR_COMMAND_BYTE: cfg_ff.command_byte <= csr_wdata[7:0];
            default:          cfg_ff.command_byte <= cfg_ff.command_byte;
         endcase
      end
   end

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;

   laft_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .step   (accept),
      .item   (req_data),
      .cfg    (cfg_ff),
      .result (result)
   );

   // output register with a skid entry behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept;
            out_data_in  = result;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

`default_nettype wire

/* hdl/laft_checker.sv */
// port-level checks for the led address frame transmitter, bound to the top level
`default_nettype none

module laft_checker (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   input  wire laft_pkg::rsp_type                     rsp_data
);

   // end of frame leaves the line high and the block idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_done |-> !rsp_data.busy_res && rsp_data.line_level)
      else $error("frame_done with busy or low line");

   // an idle line is always high
   a_idle_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.busy_res |-> rsp_data.line_level)
      else $error("line low while idle");

   // no result straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind led_address_frame_transmitter_core laft_checker u_laft_checker (.*);

`default_nettype wire

/* verif/testbench.sv */
// self-checking testbench for the led address frame transmitter core
`timescale 1ns / 100ps

module testbench;
   import laft_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_ITEMS = 330;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_write = 1'b0;
   logic [CSR_IDX_WIDTH-1:0]  csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   req_type pending_items[$];
   rsp_type expected_levels[$];
   rsp_type oldest_expected;
   int      error_count = 0;
   int      quiet_cycles = 0;
   int      req_gap = 0;
   int      rsp_hold = 0;
   logic    req_quiet = 1'b0;
   logic    rsp_quiet = 1'b0;

   // shadow copy of the registers and of the line sequencer
   cfg_type     shadow_cfg;
   phase_type   sh_phase;
   logic [15:0] sh_count;
   logic [3:0]  sh_bit;
   logic [1:0]  sh_byte;
   logic [7:0]  sh_pattern [FRAME_BYTES];
   logic        sh_line;

   led_address_frame_transmitter_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [7:0] flip_byte(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7-i];
      end
      return r;
   endfunction

   function automatic int at_least_one(input int n);
      return (n == 0) ? 1 : n;
   endfunction

   function automatic logic [16:0] period_length(input phase_type ph);
      case (ph)
         PH_BREAK: return {1'b0, shadow_cfg.break_ticks};
         PH_MARK:  return {9'd0, shadow_cfg.mark_ticks};
         PH_STOP:  return {8'd0, shadow_cfg.bit_ticks, 1'b0};
         default:  return {9'd0, shadow_cfg.bit_ticks};
      endcase
   endfunction

   // ticks from a start until the last stop period ends
   function automatic int frame_ticks();
      int bit_len;
      bit_len = at_least_one(int'(shadow_cfg.bit_ticks));
      return at_least_one(int'(shadow_cfg.break_ticks)) + at_least_one(int'(shadow_cfg.mark_ticks))
             + FRAME_BYTES * (9 * bit_len + at_least_one(2 * int'(shadow_cfg.bit_ticks)));
   endfunction

   // advances the shadow sequencer by one transfer and returns the line result
   function automatic rsp_type step_line(input req_type item);
      logic [11:0] ch;
      logic        done;
      rsp_type     r;
      done = 1'b0;
      if (item.action == ACTION_START) begin
         // a start while busy is dropped without advancing time
         if (sh_phase == PH_IDLE) begin
            ch = item.address * 12'd3 + 12'd1;
            sh_pattern[0] = 8'h00;
            sh_pattern[1] = flip_byte(ch[7:0]);
            sh_pattern[2] = flip_byte(8'd240 - {4'd0, ch[11:8]} * 8'd15);
            sh_pattern[3] = flip_byte(shadow_cfg.command_byte);
            sh_phase = PH_BREAK;
            sh_count = '0;
            sh_bit = '0;
            sh_byte = '0;
            sh_line = 1'b0;
         end
      end else if (sh_phase != PH_IDLE) begin
         sh_count = sh_count + 16'd1;
         // a zero length ends on the first tick
         if ({1'b0, sh_count} >= period_length(sh_phase)) begin
            sh_count = '0;
            case (sh_phase)
               PH_BREAK: begin
                  sh_phase = PH_MARK;
                  sh_line = 1'b1;
               end
               PH_MARK: begin
                  sh_phase = PH_START;
                  sh_line = 1'b0;
               end
               PH_START: begin
                  sh_phase = PH_DATA;
                  sh_bit = '0;
                  sh_line = sh_pattern[sh_byte][0];
               end
               PH_DATA: begin
                  sh_bit = sh_bit + 4'd1;
                  if (sh_bit >= 4'd8) begin
                     sh_phase = PH_STOP;
                     sh_line = 1'b1;
                  end else begin
                     sh_line = sh_pattern[sh_byte][sh_bit[2:0]];
                  end
               end
               PH_STOP: begin
                  if (int'(sh_byte) >= FRAME_BYTES - 1) begin
                     sh_phase = PH_IDLE;
                     sh_byte = '0;
                     sh_bit = '0;
                     sh_line = 1'b1;
                     done = 1'b1;
                  end else begin
                     sh_byte = sh_byte + 2'd1;
                     sh_bit = '0;
                     sh_phase = PH_START;
                     sh_line = 1'b0;
                  end
               end
               default: begin
                  sh_phase = PH_IDLE;
                  sh_line = 1'b1;
               end
            endcase
         end
      end
      r.line_level = sh_line;
      r.busy_res = (sh_phase != PH_IDLE);
      r.frame_done = done;
      return r;
   endfunction

   // mostly no gap, some short ones, a few long ones
   function automatic int pick_gap(input logic quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void check_field(input string name, input logic want, input logic got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0b got %0b", $time, name, want, got);
      end
   endfunction

   // driver: one transfer per handshake, fed from pending_items
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_levels.push_back(step_line(req_data));
            if ($urandom_range(0, 299) == 0) req_quiet <= !req_quiet;
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               req_data <= pending_items.pop_front();
               req_valid <= 1'b1;
               req_gap <= pick_gap(req_quiet);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each result with the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_levels.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, expected none got %p", $time, rsp_data);
            end else begin
               oldest_expected = expected_levels.pop_front();
               check_field("line_level", oldest_expected.line_level, rsp_data.line_level);
               check_field("busy_res", oldest_expected.busy_res, rsp_data.busy_res);
               check_field("frame_done", oldest_expected.frame_done, rsp_data.frame_done);
            end
         end
         if ($urandom_range(0, 499) == 0) rsp_quiet <= !rsp_quiet;
         if (rsp_hold > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold <= rsp_hold - 1;
         end else begin
            rsp_hold <= pick_gap(rsp_quiet);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_BIT_TICKS:    shadow_cfg.bit_ticks = value[7:0];
         CSR_BREAK_TICKS:  shadow_cfg.break_ticks = value;
         CSR_MARK_TICKS:   shadow_cfg.mark_ticks = value[7:0];
         CSR_COMMAND_BYTE: shadow_cfg.command_byte = value[7:0];
         default: ;
      endcase
   endtask

   // junk in the unused upper bits of the byte wide registers must be dropped
   task automatic load_config(input logic [7:0] bt, input logic [15:0] bk,
                              input logic [7:0] mk, input logic [7:0] cmd, input logic junk);
      logic [7:0] fill;
      fill = junk ? 8'($urandom_range(1, 255)) : 8'h00;
      write_reg(CSR_BIT_TICKS, {fill, bt});
      write_reg(CSR_BREAK_TICKS, bk);
      write_reg(CSR_MARK_TICKS, {fill, mk});
      write_reg(CSR_COMMAND_BYTE, {fill, cmd});
      @(posedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   task automatic queue_item(input logic act, input logic [9:0] addr);
      req_type it;
      it.action = act;
      it.address = addr;
      pending_items.push_back(it);
   endtask

   task automatic queue_ticks(input int n);
      repeat (n) queue_item(ACTION_TICK, 10'($urandom_range(0, 1023)));
   endtask

   // a start and exactly the ticks that finish its frame, ignored starts mixed in
   task automatic run_frame(input logic [9:0] addr, input int busy_odds);
      int total;
      total = frame_ticks();
      queue_item(ACTION_START, addr);
      for (int i = 0; i < total; i++) begin
         if (busy_odds != 0 && $urandom_range(1, busy_odds) == 1)
            queue_item(ACTION_START, 10'($urandom_range(0, 1023)));
         queue_item(ACTION_TICK, 10'($urandom_range(0, 1023)));
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_levels.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      int random_items;
      int batch;
      int len;
      shadow_cfg.bit_ticks = BIT_TICKS_RESET;
      shadow_cfg.break_ticks = BREAK_TICKS_RESET;
      shadow_cfg.mark_ticks = MARK_TICKS_RESET;
      shadow_cfg.command_byte = COMMAND_BYTE_RESET;
      sh_phase = PH_IDLE;
      sh_count = '0;
      sh_bit = '0;
      sh_byte = '0;
      sh_line = 1'b1;
      for (int i = 0; i < FRAME_BYTES; i++) sh_pattern[i] = 8'h00;
      random_items = 0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: ticks while idle, a start, a start while busy, part of the break
      queue_item(ACTION_TICK, 10'h3FF);
      queue_item(ACTION_TICK, 10'h000);
      queue_item(ACTION_START, 10'd0);
      queue_item(ACTION_START, 10'd1023);
      queue_ticks(20);
      wait_drained();

      // shortest periods cut the running break short, then the channel high byte boundary
      load_config(8'd1, 16'd1, 8'd1, 8'h00, 1'b0);
      queue_ticks(frame_ticks());
      run_frame(10'd85, 0);
      run_frame(10'd84, 0);
      queue_ticks(2);
      wait_drained();

      // zero lengths behave as one tick
      load_config(8'd0, 16'd0, 8'd0, 8'hFF, 1'b1);
      run_frame(10'd1023, 0);
      run_frame(10'h155, 0);
      wait_drained();

      // longest periods: part of a long break with starts dropped while busy
      load_config(8'd255, 16'hFFFF, 8'd255, 8'hA5, 1'b1);
      queue_item(ACTION_START, 10'd1023);
      repeat (40) begin
         if ($urandom_range(0, 7) == 0)
            queue_item(ACTION_START, 10'($urandom_range(0, 1023)));
         queue_item(ACTION_TICK, 10'($urandom_range(0, 1023)));
      end
      wait_drained();

      while (random_items < RANDOM_ITEMS) begin
         load_config(($urandom_range(0, 9) == 0) ? 8'($urandom_range(3, 8))
                                                 : 8'($urandom_range(0, 2)),
                     ($urandom_range(0, 9) == 0) ? 16'($urandom_range(11, 60))
                                                 : 16'($urandom_range(0, 10)),
                     ($urandom_range(0, 9) == 0) ? 8'($urandom_range(5, 40))
                                                 : 8'($urandom_range(0, 4)),
                     8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         batch = $urandom_range(1, 3);
         repeat (batch) begin
            if ($urandom_range(0, 3) != 0) begin
               run_frame(10'($urandom_range(0, 1023)), ($urandom_range(0, 1) == 0) ? 0 : 30);
               queue_ticks($urandom_range(0, 3));
            end else begin
               // noise: a cut short or restarted sequence
               len = $urandom_range(1, 30);
               repeat (len)
                  queue_item(($urandom_range(0, 3) == 0) ? ACTION_START : ACTION_TICK,
                             10'($urandom_range(0, 1023)));
            end
         end
         random_items += pending_items.size();
         wait_drained();
         // finish a frame still running before the next settings
         if (sh_phase != PH_IDLE) begin
            queue_ticks(frame_ticks());
            random_items += pending_items.size();
            wait_drained();
         end
      end

      repeat (16) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/laft_pkg.sv
hdl/laft_sequencer.sv
hdl/led_address_frame_transmitter_core.sv
hdl/laft_checker.sv
verif/testbench.sv
